### hw/rtl/rtpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpf_pkg - shared types and constants
// Payload structs, register indexes and rotation codes for the touch filter.
// ----------------------------------------------------------------------------
package rtpf_pkg;

   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned PRESSURE_W = 13;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 13;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_MIN_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_MAX_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_MIN_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_MAX_Y = 3'd6;

   // rotation codes
   localparam logic [1:0] ROT_SWAP_MIRROR_X = 2'd0;
   localparam logic [1:0] ROT_NORMAL        = 2'd1;
   localparam logic [1:0] ROT_SWAP_MIRROR_Y = 2'd2;
   localparam logic [1:0] ROT_MIRROR_BOTH   = 2'd3;

   // reset values
   localparam logic [1:0]            RST_ROTATION  = ROT_NORMAL;
   localparam logic [PRESSURE_W-1:0] RST_THRESHOLD = 13'd400;
   localparam logic [7:0]            RST_INTERVAL  = 8'd3;
   localparam logic [SAMPLE_W-1:0]   RST_INIT_MIN  = 12'd4095;
   localparam logic [SAMPLE_W-1:0]   RST_INIT_MAX  = 12'd0;

   typedef struct packed {
      logic [31:0]         now_ms;
      logic [SAMPLE_W-1:0] press_one;
      logic [SAMPLE_W-1:0] press_two;
      logic [SAMPLE_W-1:0] first_axis_a;
      logic [SAMPLE_W-1:0] first_axis_b;
      logic [SAMPLE_W-1:0] first_axis_c;
      logic [SAMPLE_W-1:0] second_axis_a;
      logic [SAMPLE_W-1:0] second_axis_b;
      logic [SAMPLE_W-1:0] second_axis_c;
   } req_payload_type;

   typedef struct packed {
      logic                  is_touched;
      logic                  frame_skipped;
      logic [PRESSURE_W-1:0] pressure;
      logic [SAMPLE_W-1:0]   raw_x;
      logic [SAMPLE_W-1:0]   raw_y;
      logic [8:0]            screen_x;
      logic [7:0]            screen_y;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] wr_data;
   } csr_payload_type;

endpackage

### hw/rtl/rtpf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpf_if - channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface rtpf_req_if;
   logic                     valid;
   logic                     ready;
   rtpf_pkg::req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rtpf_rsp_if;
   logic                     valid;
   logic                     ready;
   rtpf_pkg::rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rtpf_csr_if;
   logic                     valid;
   logic                     ready;
   rtpf_pkg::csr_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/rtpf_pair_avg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpf_pair_avg - axis lane
// Averages the two closest of three samples; ties prefer a+b, then a+c.
// ----------------------------------------------------------------------------
module rtpf_pair_avg (
   input  logic [rtpf_pkg::SAMPLE_W-1:0] samp_a,
   input  logic [rtpf_pkg::SAMPLE_W-1:0] samp_b,
   input  logic [rtpf_pkg::SAMPLE_W-1:0] samp_c,
   output logic [rtpf_pkg::SAMPLE_W-1:0] avg
);
   import rtpf_pkg::*;

   logic [SAMPLE_W-1:0] d_ab, d_ac, d_bc;
   logic [SAMPLE_W:0]   sum_ab, sum_ac, sum_bc;

   assign d_ab = (samp_a > samp_b) ? samp_a - samp_b : samp_b - samp_a;
   assign d_ac = (samp_a > samp_c) ? samp_a - samp_c : samp_c - samp_a;
   assign d_bc = (samp_b > samp_c) ? samp_b - samp_c : samp_c - samp_b;

   assign sum_ab = {1'b0, samp_a} + {1'b0, samp_b};
   assign sum_ac = {1'b0, samp_a} + {1'b0, samp_c};
   assign sum_bc = {1'b0, samp_b} + {1'b0, samp_c};

   always_comb begin
      if (d_ab <= d_ac && d_ab <= d_bc) begin
         avg = sum_ab[SAMPLE_W:1];
      end else if (d_ac <= d_ab && d_ac <= d_bc) begin
         avg = sum_ac[SAMPLE_W:1];
      end else begin
         avg = sum_bc[SAMPLE_W:1];
      end
   end

endmodule

### hw/rtl/rtpf_scale_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpf_scale_div - screen scaling lane
// (value - lo) * SIZE / (hi - lo): a multiply step, then one quotient bit
// per cycle by restoring division. An empty window or a value below lo gives zero.
// ----------------------------------------------------------------------------
module rtpf_scale_div #(
   parameter  int SIZE = 320,
   localparam int SW   = $clog2(SIZE + 1),
   localparam int NW   = rtpf_pkg::SAMPLE_W + SW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rtpf_pkg::SAMPLE_W-1:0] value,
   input  logic [rtpf_pkg::SAMPLE_W-1:0] lo,
   input  logic [rtpf_pkg::SAMPLE_W-1:0] hi,
   output logic                          done,
   output logic [NW-1:0]                 quot
);
   import rtpf_pkg::*;

   localparam int CW = $clog2(NW + 1);

   typedef enum logic [1:0] {D_IDLE, D_MULT, D_RUN} div_state_type;

   div_state_type       state_ff;
   logic                done_ff;
   logic                empty_ff;
   logic [SAMPLE_W-1:0] diff_ff;
   logic [SAMPLE_W-1:0] den_ff;
   logic [SAMPLE_W-1:0] rem_ff;
   logic [NW-1:0]       num_ff;
   logic [CW-1:0]       cnt_ff;

   logic [SAMPLE_W:0]   trial;
   logic                take;
   logic [SAMPLE_W:0]   trial_sub;

   assign trial     = {rem_ff, num_ff[NW-1]};
   assign take      = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  done_ff  <= 1'b0;
                  empty_ff <= (hi <= lo) || (value < lo);
                  diff_ff  <= value - lo;
                  den_ff   <= hi - lo;
                  state_ff <= D_MULT;
               end
            end
            D_MULT: begin
               num_ff   <= NW'(diff_ff) * NW'(SIZE);
               rem_ff   <= '0;
               cnt_ff   <= CW'(NW);
               state_ff <= D_RUN;
            end
            D_RUN: begin
               // quotient bits shift in where numerator bits leave
               rem_ff <= take ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
               num_ff <= {num_ff[NW-2:0], take};
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quot = empty_ff ? '0 : num_ff;

endmodule

### hw/rtl/resistive_touch_point_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resistive_touch_point_filter_top - touch frame filter and screen scaler
// Usage:
//   req_chan : one measurement frame per request (time, z1/z2, 3+3 samples).
//   rsp_chan : one result per request: touch flag, skip flag, held pressure,
//              held rotated point and its screen coordinates.
//   csr_chan : register writes, always ready; write only while idle.
//   An accepted request runs capture, update, window, lane start, then the
//   two scaling lanes in parallel, each a multiply step followed by a
//   restoring division; the wait ends once both lanes are done. One request
//   is in flight at a time: the next is taken only after this result has
//   been loaded into the output register.
//   A finished result sits in the output register; the next request is taken
//   while it waits. If the receiver still stalls when the following result
//   is ready, the block holds that result and takes no new request.
//   Reset loads register defaults, clears held point/pressure/time and sets
//   the calibration window to its empty default.
// ----------------------------------------------------------------------------
module resistive_touch_point_filter_top #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic       clock,
   input  logic       reset,
   rtpf_req_if.sink   req_chan,
   rtpf_rsp_if.source rsp_chan,
   rtpf_csr_if.sink   csr_chan
);
   import rtpf_pkg::*;

   localparam int XNW = SAMPLE_W + $clog2(SCREEN_WIDTH + 1);
   localparam int YNW = SAMPLE_W + $clog2(SCREEN_HEIGHT + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_UPDATE, ST_WINDOW, ST_START, ST_WAIT, ST_DONE
   } state_type;

   state_type             state_ff;
   req_payload_type       frame_ff;
   logic [1:0]            rot_ff;
   logic [PRESSURE_W-1:0] thr_ff;
   logic [7:0]            intv_ff;
   logic [31:0]           last_good_ff;
   logic [PRESSURE_W-1:0] held_p_ff;
   logic [SAMPLE_W-1:0]   held_x_ff, held_y_ff;
   logic [SAMPLE_W-1:0]   win_min_x_ff, win_max_x_ff, win_min_y_ff, win_max_y_ff;
   logic                  skip_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff;

   logic [SAMPLE_W-1:0]   avg_f, avg_s;
   logic [31:0]           elapsed;
   logic                  skipped;
   logic [PRESSURE_W-1:0] z_sum, z_val;
   logic [SAMPLE_W-1:0]   rot_x, rot_y;
   logic                  div_start;
   logic                  done_x, done_y;
   logic [XNW-1:0]        quot_x;
   logic [YNW-1:0]        quot_y;
   logic                  csr_write;

   // axis lanes
   rtpf_pair_avg u_lane_f (
      .samp_a (frame_ff.first_axis_a),
      .samp_b (frame_ff.first_axis_b),
      .samp_c (frame_ff.first_axis_c),
      .avg    (avg_f)
   );

   rtpf_pair_avg u_lane_s (
      .samp_a (frame_ff.second_axis_a),
      .samp_b (frame_ff.second_axis_b),
      .samp_c (frame_ff.second_axis_c),
      .avg    (avg_s)
   );

   // scaling lanes
   rtpf_scale_div #(.SIZE(SCREEN_WIDTH)) u_scale_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .value (held_x_ff),
      .lo    (win_min_x_ff),
      .hi    (win_max_x_ff),
      .done  (done_x),
      .quot  (quot_x)
   );

   rtpf_scale_div #(.SIZE(SCREEN_HEIGHT)) u_scale_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .value (held_y_ff),
      .lo    (win_min_y_ff),
      .hi    (win_max_y_ff),
      .done  (done_y),
      .quot  (quot_y)
   );

   assign elapsed = frame_ff.now_ms - last_good_ff;
   assign skipped = elapsed < {24'd0, intv_ff};
   assign z_sum   = {1'b0, frame_ff.press_one} + {1'b0, FULL_SCALE};
   assign z_val   = (z_sum > {1'b0, frame_ff.press_two})
                    ? z_sum - {1'b0, frame_ff.press_two} : '0;

   always_comb begin
      case (rot_ff)
         ROT_SWAP_MIRROR_X: begin
            rot_x = FULL_SCALE - avg_s;
            rot_y = avg_f;
         end
         ROT_NORMAL: begin
            rot_x = avg_f;
            rot_y = avg_s;
         end
         ROT_SWAP_MIRROR_Y: begin
            rot_x = avg_s;
            rot_y = FULL_SCALE - avg_f;
         end
         default: begin
            rot_x = FULL_SCALE - avg_f;
            rot_y = FULL_SCALE - avg_s;
         end
      endcase
   end

   assign div_start      = (state_ff == ST_START);
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rot_ff       <= RST_ROTATION;
         thr_ff       <= RST_THRESHOLD;
         intv_ff      <= RST_INTERVAL;
         last_good_ff <= '0;
         held_p_ff    <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         win_min_x_ff <= RST_INIT_MIN;
         win_max_x_ff <= RST_INIT_MAX;
         win_min_y_ff <= RST_INIT_MIN;
         win_max_y_ff <= RST_INIT_MAX;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // init writes load the window bound directly
         if (csr_write) begin
            case (csr_chan.data.reg_index)
               REG_ROTATION:   rot_ff       <= csr_chan.data.wr_data[1:0];
               REG_THRESHOLD:  thr_ff       <= csr_chan.data.wr_data;
               REG_INTERVAL:   intv_ff      <= csr_chan.data.wr_data[7:0];
               REG_INIT_MIN_X: win_min_x_ff <= csr_chan.data.wr_data[SAMPLE_W-1:0];
               REG_INIT_MAX_X: win_max_x_ff <= csr_chan.data.wr_data[SAMPLE_W-1:0];
               REG_INIT_MIN_Y: win_min_y_ff <= csr_chan.data.wr_data[SAMPLE_W-1:0];
               REG_INIT_MAX_Y: win_max_y_ff <= csr_chan.data.wr_data[SAMPLE_W-1:0];
               default: ;
            endcase
         end

         // ST_DONE reloads the register itself when the old result leaves
         if (rsp_valid_ff && rsp_chan.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  frame_ff <= req_chan.data;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               skip_ff <= skipped;
               if (!skipped) begin
                  if (z_val < thr_ff) begin
                     held_p_ff <= '0;
                  end else begin
                     held_p_ff    <= z_val;
                     last_good_ff <= frame_ff.now_ms;
                     held_x_ff    <= rot_x;
                     held_y_ff    <= rot_y;
                  end
               end
               state_ff <= ST_WINDOW;
            end
            ST_WINDOW: begin
               if (held_x_ff < win_min_x_ff) win_min_x_ff <= held_x_ff;
               if (held_x_ff > win_max_x_ff) win_max_x_ff <= held_x_ff;
               if (held_y_ff < win_min_y_ff) win_min_y_ff <= held_y_ff;
               if (held_y_ff > win_max_y_ff) win_max_y_ff <= held_y_ff;
               state_ff <= ST_START;
            end
            ST_START: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (done_x && done_y) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff               <= 1'b1;
                  rsp_data_ff.is_touched     <= held_p_ff >= thr_ff;
                  rsp_data_ff.frame_skipped  <= skip_ff;
                  rsp_data_ff.pressure       <= held_p_ff;
                  rsp_data_ff.raw_x          <= held_x_ff;
                  rsp_data_ff.raw_y          <= held_y_ff;
                  rsp_data_ff.screen_x       <= 9'(quot_x);
                  rsp_data_ff.screen_y       <= 8'(quot_y);
                  state_ff                   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### hw/rtl/rtpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpf_checker - port-level assertions
// Watches the request and response channels of the touch filter top level.
// ----------------------------------------------------------------------------
module rtpf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rtpf_pkg::rsp_payload_type rsp_data
);
   import rtpf_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while another is in flight");

   // a response cannot appear right after a request is taken
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##1 !$rose(rsp_valid))
      else $error("response too early after request");

   // a touched result needs pressure != 0 or the touch flag, so it always passes
   a_skip_zero_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_touched |-> rsp_data.pressure != '0
      || rsp_data.is_touched)
      else $error("touch flag inconsistent");

   // nothing valid right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind resistive_touch_point_filter_top rtpf_checker u_rtpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

### tb/touch_filter_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_filter_check - touch point predictor and result comparator
// Follows register writes and accepted frames, predicts each held point and
// its screen coordinates, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module touch_filter_check #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  rtpf_pkg::req_payload_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rtpf_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  rtpf_pkg::csr_payload_type csr_data,
   output int                        fail_count,
   output int                        pending,
   output int                        touched_count,
   output int                        skipped_count
);
   import rtpf_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [1:0]            rot_mode;
   logic [PRESSURE_W-1:0] touch_threshold;
   logic [7:0]            holdoff_ms;
   logic [31:0]           last_touch_ms;
   logic [PRESSURE_W-1:0] held_press;
   logic [SAMPLE_W-1:0]   hold_x, hold_y;
   logic [SAMPLE_W-1:0]   win_lo_x, win_hi_x, win_lo_y, win_hi_y;

   rsp_payload_type expected_points[$];
   int              result_index;

   function automatic logic [SAMPLE_W-1:0] pair_mean(input logic [SAMPLE_W-1:0] a, b, c);
      logic [SAMPLE_W-1:0] dab, dac, dbc;
      logic [SAMPLE_W:0]   total;
      dab = (a > b) ? a - b : b - a;
      dac = (a > c) ? a - c : c - a;
      dbc = (b > c) ? b - c : c - b;
      // ties prefer a+b, then a+c
      if (dab <= dac && dab <= dbc)
         total = a + b;
      else if (dac <= dab && dac <= dbc)
         total = a + c;
      else
         total = b + c;
      return total[SAMPLE_W:1];
   endfunction

   function automatic int scaled(input logic [SAMPLE_W-1:0] v, lo, hi, input int span);
      if (hi <= lo || v < lo)
         return 0;
      return (int'(v - lo) * span) / int'(hi - lo);
   endfunction

   task automatic advance_filter(input req_payload_type f, output rsp_payload_type r);
      logic                skip;
      int                  z;
      logic [SAMPLE_W-1:0] fm, sm;
      logic [31:0]         age;
      age  = f.now_ms - last_touch_ms;
      skip = age < 32'(holdoff_ms);
      if (!skip) begin
         z = int'(f.press_one) + int'(FULL_SCALE) - int'(f.press_two);
         if (z < 0)
            z = 0;
         if (z < int'(touch_threshold)) begin
            held_press = '0;
         end else begin
            fm = pair_mean(f.first_axis_a, f.first_axis_b, f.first_axis_c);
            sm = pair_mean(f.second_axis_a, f.second_axis_b, f.second_axis_c);
            held_press    = PRESSURE_W'(z);
            last_touch_ms = f.now_ms;
            case (rot_mode)
               ROT_SWAP_MIRROR_X: begin
                  hold_x = FULL_SCALE - sm;
                  hold_y = fm;
               end
               ROT_NORMAL: begin
                  hold_x = fm;
                  hold_y = sm;
               end
               ROT_SWAP_MIRROR_Y: begin
                  hold_x = sm;
                  hold_y = FULL_SCALE - fm;
               end
               default: begin
                  hold_x = FULL_SCALE - fm;
                  hold_y = FULL_SCALE - sm;
               end
            endcase
         end
      end
      // the window widens on every frame, skipped or not
      if (hold_x < win_lo_x) win_lo_x = hold_x;
      if (hold_x > win_hi_x) win_hi_x = hold_x;
      if (hold_y < win_lo_y) win_lo_y = hold_y;
      if (hold_y > win_hi_y) win_hi_y = hold_y;

      r.is_touched    = held_press >= touch_threshold;
      r.frame_skipped = skip;
      r.pressure      = held_press;
      r.raw_x         = hold_x;
      r.raw_y         = hold_y;
      r.screen_x      = 9'(scaled(hold_x, win_lo_x, win_hi_x, SCREEN_WIDTH));
      r.screen_y      = 8'(scaled(hold_y, win_lo_y, win_hi_y, SCREEN_HEIGHT));
      if (r.is_touched) touched_count++;
      if (skip) skipped_count++;
   endtask

   initial begin
      fail_count    = 0;
      pending       = 0;
      touched_count = 0;
      skipped_count = 0;
      result_index  = 0;
   end

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         rot_mode        = RST_ROTATION;
         touch_threshold = RST_THRESHOLD;
         holdoff_ms      = RST_INTERVAL;
         last_touch_ms   = '0;
         held_press      = '0;
         hold_x          = '0;
         hold_y          = '0;
         win_lo_x        = RST_INIT_MIN;
         win_hi_x        = RST_INIT_MAX;
         win_lo_y        = RST_INIT_MIN;
         win_hi_y        = RST_INIT_MAX;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            // an init write also reloads the matching window bound
            case (csr_data.reg_index)
               REG_ROTATION:   rot_mode        = csr_data.wr_data[1:0];
               REG_THRESHOLD:  touch_threshold = csr_data.wr_data;
               REG_INTERVAL:   holdoff_ms      = csr_data.wr_data[7:0];
               REG_INIT_MIN_X: win_lo_x        = csr_data.wr_data[SAMPLE_W-1:0];
               REG_INIT_MAX_X: win_hi_x        = csr_data.wr_data[SAMPLE_W-1:0];
               REG_INIT_MIN_Y: win_lo_y        = csr_data.wr_data[SAMPLE_W-1:0];
               REG_INIT_MAX_Y: win_hi_y        = csr_data.wr_data[SAMPLE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_filter(req_data, want);
            expected_points.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            result_index++;
            if (expected_points.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("result %0d arrived with no request outstanding", result_index);
            end else begin
               want = expected_points.pop_front();
               if (rsp_data.is_touched !== want.is_touched ||
                   rsp_data.frame_skipped !== want.frame_skipped ||
                   rsp_data.pressure !== want.pressure ||
                   rsp_data.raw_x !== want.raw_x || rsp_data.raw_y !== want.raw_y ||
                   rsp_data.screen_x !== want.screen_x ||
                   rsp_data.screen_y !== want.screen_y) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("result %0d: want touch=%0d skip=%0d p=%0d raw=(%0d,%0d) scr=(%0d,%0d)",
                              result_index, want.is_touched, want.frame_skipped, want.pressure,
                              want.raw_x, want.raw_y, want.screen_x, want.screen_y);
                     $display("           got  touch=%0d skip=%0d p=%0d raw=(%0d,%0d) scr=(%0d,%0d)",
                              rsp_data.is_touched, rsp_data.frame_skipped, rsp_data.pressure,
                              rsp_data.raw_x, rsp_data.raw_y, rsp_data.screen_x,
                              rsp_data.screen_y);
                  end
               end
            end
         end
      end
      pending = expected_points.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - touch point filter top level test
// Drives directed and random measurement frames under several register
// settings, with random gaps and stalls in all phases but one; the check module judges every result.
// ----------------------------------------------------------------------------
module testbench;
   import rtpf_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_ITEMS    = 80;
   localparam int IDLE_PCT       = 19;
   localparam int SCREEN_W       = 320;
   localparam int SCREEN_H       = 240;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bit                    sender_gaps = 1'b1;
   bit                    sink_stalls = 1'b1;
   logic [31:0]           frame_ms    = '0;
   logic [PRESSURE_W-1:0] cur_thr     = RST_THRESHOLD;
   logic [7:0]            cur_intv    = RST_INTERVAL;
   int                    frames_sent = 0;
   int                    setting_count = 1;
   int                    quiet_cycles  = 0;

   int fail_count, pending, touched_count, skipped_count;

   rtpf_req_if req_chan ();
   rtpf_rsp_if rsp_chan ();
   rtpf_csr_if csr_chan ();

   resistive_touch_point_filter_top #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   touch_filter_check #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H)
   ) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data      (req_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_chan.data),
      .csr_valid     (csr_chan.valid),
      .csr_ready     (csr_chan.ready),
      .csr_data      (csr_chan.data),
      .fail_count    (fail_count),
      .pending       (pending),
      .touched_count (touched_count),
      .skipped_count (skipped_count)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && (!sink_stalls || $urandom_range(99) >= IDLE_PCT);
   end

   // give up once nothing has moved on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_payload_type make_frame(input logic [31:0] now,
         input logic [SAMPLE_W-1:0] z1, z2, fa, fb, fc, sa, sb, sc);
      req_payload_type f;
      f = {now, z1, z2, fa, fb, fc, sa, sb, sc};
      return f;
   endfunction

   // three samples of one axis, mostly clustered around a random point
   function automatic logic [3*SAMPLE_W-1:0] sample_triplet();
      logic [3*SAMPLE_W-1:0] t;
      int                    base, v, k;
      if ($urandom_range(99) < 70) begin
         base = int'($urandom_range(4095));
         for (k = 0; k < 3; k++) begin
            v = base + int'($urandom_range(80)) - 40;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            t[k*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(v);
         end
      end else begin
         t = {SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom)};
      end
      return t;
   endfunction

   task automatic random_frame(output req_payload_type f);
      int pick, target, lo, hi, z1;
      pick = $urandom_range(99);
      if (pick < 20)
         frame_ms = frame_ms + $urandom_range(cur_intv);
      else if (pick < 88)
         frame_ms = frame_ms + cur_intv + $urandom_range(20);
      else if (pick < 94)
         frame_ms = 32'hFFFF_FFFF - $urandom_range(30);
      else
         frame_ms = $urandom;
      // pick the pressure first, then split it into z1 and z2
      pick = $urandom_range(99);
      if (pick < 5)
         target = 0;
      else if (pick < 10)
         target = 8190;
      else if (pick < 40)
         target = int'(cur_thr) + int'($urandom_range(4)) - 2;
      else if (pick < 75)
         target = int'($urandom_range(8190, cur_thr));
      else
         target = int'($urandom_range(8190));
      if (target < 0) target = 0;
      if (target > 8190) target = 8190;
      lo = (target > 4095) ? target - 4095 : 0;
      hi = (target < 4095) ? target : 4095;
      z1 = int'($urandom_range(hi, lo));
      f.now_ms    = frame_ms;
      f.press_one = SAMPLE_W'(z1);
      f.press_two = SAMPLE_W'(z1 + 4095 - target);
      {f.first_axis_a, f.first_axis_b, f.first_axis_c}    = sample_triplet();
      {f.second_axis_a, f.second_axis_b, f.second_axis_c} = sample_triplet();
   endtask

   // called at a falling edge; valid stays high after the request so that
   // back-to-back requests need no second assignment in one step
   task automatic send_frame(input req_payload_type f);
      while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= f;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      frames_sent++;
   endtask

   task automatic run_random(input int count);
      req_payload_type f;
      repeat (count) begin
         random_frame(f);
         send_frame(f);
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= {idx, value};
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
   endtask

   // unused upper data bits carry noise; the block must ignore them
   task automatic configure(input logic [1:0] rot, input logic [PRESSURE_W-1:0] thr,
         input logic [7:0] holdoff, input logic [SAMPLE_W-1:0] lo_x, hi_x, lo_y, hi_y);
      wait_drained();
      write_reg(REG_ROTATION,   {11'($urandom), rot});
      write_reg(REG_THRESHOLD,  thr);
      write_reg(REG_INTERVAL,   {5'($urandom), holdoff});
      write_reg(REG_INIT_MIN_X, {1'($urandom), lo_x});
      write_reg(REG_INIT_MAX_X, {1'($urandom), hi_x});
      write_reg(REG_INIT_MIN_Y, {1'($urandom), lo_y});
      write_reg(REG_INIT_MAX_Y, {1'($urandom), hi_y});
      write_reg(REG_UNUSED,     CSR_DATA_W'($urandom));
      csr_chan.valid <= 1'b0;
      cur_thr  = thr;
      cur_intv = holdoff;
      setting_count++;
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: hold-off 3 ms, threshold 400, empty window
      send_frame(make_frame(32'd0, 12'd0, 12'd0, 12'd5, 12'd6, 12'd7, 12'd8, 12'd9, 12'd10));
      send_frame(make_frame(32'd3, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd4095,
                            12'd4095, 12'd4095, 12'd0));
      send_frame(make_frame(32'd4, 12'd4095, 12'd0, 12'd100, 12'd100, 12'd100,
                            12'd200, 12'd200, 12'd200));
      send_frame(make_frame(32'd10, 12'd0, 12'd4095, 12'd300, 12'd300, 12'd300,
                            12'd300, 12'd300, 12'd300));
      // pressure exactly at threshold, then one below; pair ties
      send_frame(make_frame(32'd20, 12'd400, 12'd4095, 12'd100, 12'd200, 12'd300,
                            12'd100, 12'd300, 12'd200));
      send_frame(make_frame(32'd30, 12'd399, 12'd4095, 12'd900, 12'd901, 12'd902,
                            12'd50, 12'd60, 12'd70));
      send_frame(make_frame(32'd40, 12'd2048, 12'd2048, 12'd1000, 12'd1000, 12'd1000,
                            12'd300, 12'd100, 12'd200));
      send_frame(make_frame(32'd50, 12'd4095, 12'd4095, 12'd0, 12'd2000, 12'd2001,
                            12'd4095, 12'd4094, 12'd0));
      send_frame(make_frame(32'd60, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095,
                            12'd0, 12'd0, 12'd0));
      // time wraps past 2^32
      send_frame(make_frame(32'hFFFF_FFFF, 12'd3000, 12'd1000, 12'd2000, 12'd2010, 12'd2020,
                            12'd1500, 12'd1490, 12'd1480));
      send_frame(make_frame(32'd1, 12'd3000, 12'd1000, 12'd10, 12'd20, 12'd30,
                            12'd40, 12'd50, 12'd60));
      send_frame(make_frame(32'd2, 12'd3000, 12'd1000, 12'd10, 12'd20, 12'd30,
                            12'd40, 12'd50, 12'd60));
      send_frame(make_frame(32'h8000_0000, 12'd2500, 12'd2400, 12'd3000, 12'd3100, 12'd3050,
                            12'd700, 12'd710, 12'd720));
      send_frame(make_frame(32'h8000_0001, 12'd2500, 12'd2400, 12'd1, 12'd2, 12'd3,
                            12'd4, 12'd5, 12'd6));
      send_frame(make_frame(32'h8000_0100, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                            12'd4095, 12'd4095, 12'd4095));
      send_frame(make_frame(32'h8000_0200, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
                            12'd0, 12'd0, 12'd0));
      frame_ms = 32'h8000_0200;

      // zero threshold and hold-off, full window
      configure(ROT_SWAP_MIRROR_X, 13'd0, 8'd0, 12'd0, 12'd4095, 12'd0, 12'd4095);
      run_random(PHASE_ITEMS);

      // top threshold, longest hold-off, window collapsed to one point
      configure(ROT_SWAP_MIRROR_Y, 13'd8190, 8'd255, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
      run_random(PHASE_ITEMS);

      // a long stretch with no gaps and no stalls
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      configure(ROT_MIRROR_BOTH, 13'($urandom_range(8191)), 8'($urandom),
                12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
      run_random(PHASE_ITEMS);
      sender_gaps = 1'b1;
      sink_stalls = 1'b1;

      // sender holds off mid-phase until every result is back
      configure(ROT_NORMAL, 13'd1, 8'd1, RST_INIT_MIN, RST_INIT_MAX, RST_INIT_MIN, RST_INIT_MAX);
      run_random(PHASE_ITEMS / 2);
      wait_drained();
      run_random(PHASE_ITEMS / 2);

      repeat (2) begin
         configure(2'($urandom), 13'($urandom_range(8191)), 8'($urandom),
                   12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
         run_random(PHASE_ITEMS);
      end

      wait_drained();
      $display("Ran %0d frames under %0d register settings, every rotation included.",
               frames_sent, setting_count);
      $display("Of these %0d reported a touch and %0d fell inside the hold-off.",
               touched_count, skipped_count);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/rtpf_pkg.sv
hw/rtl/rtpf_if.sv
hw/rtl/rtpf_pair_avg.sv
hw/rtl/rtpf_scale_div.sv
hw/rtl/resistive_touch_point_filter_top.sv
hw/rtl/rtpf_checker.sv
tb/touch_filter_check.sv
tb/testbench.sv
